// File: hdl/pdl_pkg.sv
// Package for the pooled doubly linked list block.
// Holds the widths, codes, state and result types shared by the interfaces and the top level.
// Has no dependencies.
package pdl_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = 6;
    localparam int NODE_W    = 7;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    localparam logic [NODE_W-1:0] NIL = NODE_W'(POOL_SIZE);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_INS_BEFORE = 3'd4,
        MODE_INS_AFTER  = 3'd5,
        MODE_REMOVE     = 3'd6,
        MODE_GET_NTH    = 3'd7
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_PUSH_EMPTY,
        OP_INS_BEFORE,
        OP_INS_AFTER,
        OP_RELEASE
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR1,
        S_WR2,
        S_WALK,
        S_STEP,
        S_FETCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [NODE_W-1:0]   node_index;
        logic [DATA_W-1:0]   data_out;
        logic [NODE_W-1:0]   list_length;
    } t_result;

endpackage

// File: hdl/pdl_if.sv
// Valid/ready channel interfaces for the list manager's request and response items.
// Depends on pdl_pkg for field widths.
interface pdl_req_if;
    logic                          valid;
    logic                          ready;
    logic [pdl_pkg::MODE_W-1:0]    mode;
    logic [pdl_pkg::IDX_W-1:0]     target_node;
    logic [pdl_pkg::IDX_W-1:0]     position;
    logic [pdl_pkg::DATA_W-1:0]    data_in;

    modport source (output valid, mode, target_node, position, data_in, input ready);
    modport sink   (input valid, mode, target_node, position, data_in, output ready);
endinterface

interface pdl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pdl_pkg::STATUS_W-1:0]  status;
    logic [pdl_pkg::NODE_W-1:0]    node_index;
    logic [pdl_pkg::DATA_W-1:0]    data_out;
    logic [pdl_pkg::NODE_W-1:0]    list_length;

    modport source (output valid, status, node_index, data_out, list_length, input ready);
    modport sink   (input valid, status, node_index, data_out, list_length, output ready);
endinterface

// File: hdl/pdl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/pooled_doubly_linked_list_top.sv
// Pooled doubly linked list manager: one list over a pool of 64 nodes, links, payloads and the
// free-node chain in single-port-read RAMs. One item is taken at a time: after S_RD, a rejected
// item goes straight to S_EMIT, pushes on an empty list, pops and removes pass S_WR1, inserts
// and pushes on a non-empty list pass S_WR1 and S_WR2, and get nth alternates S_WALK and S_STEP
// per position step, reading one link each, before S_FETCH; S_EMIT waits while a response is held.
// Never-allocated nodes are handed out in index order from a counter, so no RAM needs clearing.
// Depends on pdl_pkg, pdl_if and pdl_ram.
module pooled_doubly_linked_list_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pdl_req_if.sink   i_req,
    pdl_rsp_if.source o_rsp
);
    localparam int IW = pdl_pkg::IDX_W;
    localparam int NW = pdl_pkg::NODE_W;
    localparam int DW = pdl_pkg::DATA_W;

    pdl_pkg::t_state  r_state, n_state;
    pdl_pkg::t_mode   r_mode, n_mode;
    pdl_pkg::t_op     r_op, n_op;
    logic [IW-1:0]    r_tgt, n_tgt;
    logic [IW-1:0]    r_pos, n_pos;
    logic [DW-1:0]    r_data, n_data;
    logic [IW-1:0]    r_t, n_t;
    logic [IW-1:0]    r_n, n_n;
    logic [NW-1:0]    r_link, n_link;
    logic [IW-1:0]    r_cur, n_cur;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic [NW-1:0]    r_head, n_head;
    logic [NW-1:0]    r_tail, n_tail;
    logic [NW-1:0]    r_count, n_count;
    logic [NW-1:0]    r_free_head, n_free_head;
    logic [NW-1:0]    r_fresh, n_fresh;
    logic [pdl_pkg::POOL_SIZE-1:0] r_live, n_live;
    pdl_pkg::t_result r_res, n_res;
    pdl_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic          next_we, prev_we, pay_we, fn_we;
    logic [IW-1:0] next_waddr, prev_waddr, pay_waddr, fn_waddr;
    logic [NW-1:0] next_wdata, prev_wdata, fn_wdata;
    logic [DW-1:0] pay_wdata;
    logic [IW-1:0] rd_addr;
    logic [NW-1:0] next_rdata, prev_rdata, fn_rdata;
    logic [DW-1:0] pay_rdata;

    logic          full, head_live, tail_live, tgt_live;
    logic [IW-1:0] alloc_n;
    logic [NW-1:0] alloc_next;

    pdl_ram #(.WIDTH(NW), .DEPTH(pdl_pkg::POOL_SIZE)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(rd_addr), .o_rdata(next_rdata)
    );
    pdl_ram #(.WIDTH(NW), .DEPTH(pdl_pkg::POOL_SIZE)) u_prev_ram (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_raddr(rd_addr), .o_rdata(prev_rdata)
    );
    pdl_ram #(.WIDTH(DW), .DEPTH(pdl_pkg::POOL_SIZE)) u_pay_ram (
        .i_clk(i_clk), .i_we(pay_we), .i_waddr(pay_waddr), .i_wdata(pay_wdata),
        .i_raddr(rd_addr), .o_rdata(pay_rdata)
    );
    // Free chain; only entries of released nodes are ever read.
    pdl_ram #(.WIDTH(NW), .DEPTH(pdl_pkg::POOL_SIZE)) u_fn_ram (
        .i_clk(i_clk), .i_we(fn_we), .i_waddr(fn_waddr), .i_wdata(fn_wdata),
        .i_raddr(r_free_head[IW-1:0]), .o_rdata(fn_rdata)
    );

    assign full      = (r_count >= pdl_pkg::NIL) || (r_free_head == pdl_pkg::NIL);
    // The head and the tail are always live nodes unless they are none.
    assign head_live = (r_head != pdl_pkg::NIL);
    assign tail_live = (r_tail != pdl_pkg::NIL);
    assign tgt_live  = r_live[r_tgt];
    assign alloc_n   = r_free_head[IW-1:0];
    // A head equal to the fresh counter has never been allocated, so its successor is implicit.
    assign alloc_next = (r_free_head == r_fresh) ? r_free_head + NW'(1) : fn_rdata;

    assign i_req.ready       = (r_state == pdl_pkg::S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.node_index  = r_out.node_index;
    assign o_rsp.data_out    = r_out.data_out;
    assign o_rsp.list_length = r_out.list_length;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_op        = r_op;
        n_tgt       = r_tgt;
        n_pos       = r_pos;
        n_data      = r_data;
        n_t         = r_t;
        n_n         = r_n;
        n_link      = r_link;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_live      = r_live;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        next_we     = 1'b0;
        prev_we     = 1'b0;
        pay_we      = 1'b0;
        fn_we       = 1'b0;
        next_waddr  = '0;
        prev_waddr  = '0;
        pay_waddr   = '0;
        fn_waddr    = '0;
        next_wdata  = '0;
        prev_wdata  = '0;
        pay_wdata   = '0;
        fn_wdata    = '0;
        rd_addr     = r_cur;

        unique case (r_state)
            pdl_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = pdl_pkg::t_mode'(i_req.mode);
                    n_tgt   = i_req.target_node;
                    n_pos   = i_req.position;
                    n_data  = i_req.data_in;
                    n_state = pdl_pkg::S_RD;
                end
            end
            pdl_pkg::S_RD: begin
                n_res.status      = pdl_pkg::ST_OK;
                n_res.node_index  = pdl_pkg::NIL;
                n_res.data_out    = '0;
                n_res.list_length = r_count;
                n_state           = pdl_pkg::S_WR1;
                unique case (r_mode) inside
                    pdl_pkg::MODE_PUSH_FRONT, pdl_pkg::MODE_PUSH_BACK: begin
                        if (full) begin
                            n_res.status = pdl_pkg::ST_FULL;
                        end else if (r_head == pdl_pkg::NIL) begin
                            n_op = pdl_pkg::OP_PUSH_EMPTY;
                        end else if (r_mode == pdl_pkg::MODE_PUSH_FRONT) begin
                            n_op = pdl_pkg::OP_INS_BEFORE;
                            n_t  = r_head[IW-1:0];
                        end else begin
                            n_op = pdl_pkg::OP_INS_AFTER;
                            n_t  = r_tail[IW-1:0];
                        end
                    end
                    pdl_pkg::MODE_POP_FRONT: begin
                        if (r_count == '0 || !head_live) begin
                            n_res.status = pdl_pkg::ST_EMPTY;
                        end else begin
                            n_op = pdl_pkg::OP_RELEASE;
                            n_t  = r_head[IW-1:0];
                        end
                    end
                    pdl_pkg::MODE_POP_BACK: begin
                        if (r_count == '0 || !tail_live) begin
                            n_res.status = pdl_pkg::ST_EMPTY;
                        end else begin
                            n_op = pdl_pkg::OP_RELEASE;
                            n_t  = r_tail[IW-1:0];
                        end
                    end
                    pdl_pkg::MODE_INS_BEFORE, pdl_pkg::MODE_INS_AFTER: begin
                        if (!tgt_live) begin
                            n_res.status = pdl_pkg::ST_BAD;
                        end else if (full) begin
                            n_res.status = pdl_pkg::ST_FULL;
                        end else begin
                            n_op = (r_mode == pdl_pkg::MODE_INS_BEFORE) ?
                                   pdl_pkg::OP_INS_BEFORE : pdl_pkg::OP_INS_AFTER;
                            n_t  = r_tgt;
                        end
                    end
                    pdl_pkg::MODE_REMOVE: begin
                        if (r_count == '0) begin
                            n_res.status = pdl_pkg::ST_EMPTY;
                        end else if (!tgt_live) begin
                            n_res.status = pdl_pkg::ST_BAD;
                        end else begin
                            n_op = pdl_pkg::OP_RELEASE;
                            n_t  = r_tgt;
                        end
                    end
                    pdl_pkg::MODE_GET_NTH: begin
                        if (r_count == '0) begin
                            n_res.status = pdl_pkg::ST_EMPTY;
                        end else if ({1'b0, r_pos} >= r_count) begin
                            n_res.status = pdl_pkg::ST_BAD;
                        end else begin
                            n_cur   = r_head[IW-1:0];
                            n_cnt   = r_pos;
                        end
                        n_state = pdl_pkg::S_WALK;
                    end
                    default: begin
                    end
                endcase
                rd_addr = n_t;
                if (n_res.status != pdl_pkg::ST_OK) begin
                    n_state = pdl_pkg::S_EMIT;
                end
            end
            pdl_pkg::S_WR1: begin
                if (r_op == pdl_pkg::OP_RELEASE) begin
                    // Unlink the node, then push it on the free chain.
                    if (prev_rdata != pdl_pkg::NIL) begin
                        next_we    = 1'b1;
                        next_waddr = prev_rdata[IW-1:0];
                        next_wdata = next_rdata;
                    end else begin
                        n_head = next_rdata;
                    end
                    if (next_rdata != pdl_pkg::NIL) begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rdata[IW-1:0];
                        prev_wdata = prev_rdata;
                    end else begin
                        n_tail = prev_rdata;
                    end
                    n_live[r_t]       = 1'b0;
                    fn_we             = 1'b1;
                    fn_waddr          = r_t;
                    fn_wdata          = r_free_head;
                    n_free_head       = {1'b0, r_t};
                    n_count           = r_count - NW'(1);
                    n_res.node_index  = {1'b0, r_t};
                    n_res.data_out    = pay_rdata;
                    n_res.list_length = r_count - NW'(1);
                    n_state           = pdl_pkg::S_EMIT;
                end else begin
                    pay_we            = 1'b1;
                    pay_waddr         = alloc_n;
                    pay_wdata         = r_data;
                    n_live[alloc_n]   = 1'b1;
                    n_free_head       = alloc_next;
                    if (r_free_head == r_fresh) begin
                        n_fresh = r_fresh + NW'(1);
                    end
                    n_count           = r_count + NW'(1);
                    n_n               = alloc_n;
                    n_res.node_index  = {1'b0, alloc_n};
                    n_res.list_length = r_count + NW'(1);
                    next_we           = 1'b1;
                    prev_we           = 1'b1;
                    next_waddr        = alloc_n;
                    prev_waddr        = alloc_n;
                    n_state           = pdl_pkg::S_WR2;
                    case (r_op)
                        pdl_pkg::OP_INS_BEFORE: begin
                            prev_wdata = prev_rdata;
                            next_wdata = {1'b0, r_t};
                            n_link     = prev_rdata;
                            if (prev_rdata == pdl_pkg::NIL) begin
                                n_head = {1'b0, alloc_n};
                            end
                        end
                        pdl_pkg::OP_INS_AFTER: begin
                            next_wdata = next_rdata;
                            prev_wdata = {1'b0, r_t};
                            n_link     = next_rdata;
                            if (next_rdata == pdl_pkg::NIL) begin
                                n_tail = {1'b0, alloc_n};
                            end
                        end
                        default: begin
                            next_wdata = pdl_pkg::NIL;
                            prev_wdata = pdl_pkg::NIL;
                            n_head     = {1'b0, alloc_n};
                            n_tail     = {1'b0, alloc_n};
                            n_state    = pdl_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            pdl_pkg::S_WR2: begin
                // Second half of a splice: the neighbor and the target point at the new node.
                if (r_op == pdl_pkg::OP_INS_BEFORE) begin
                    next_we    = (r_link != pdl_pkg::NIL);
                    next_waddr = r_link[IW-1:0];
                    next_wdata = {1'b0, r_n};
                    prev_we    = 1'b1;
                    prev_waddr = r_t;
                    prev_wdata = {1'b0, r_n};
                end else begin
                    prev_we    = (r_link != pdl_pkg::NIL);
                    prev_waddr = r_link[IW-1:0];
                    prev_wdata = {1'b0, r_n};
                    next_we    = 1'b1;
                    next_waddr = r_t;
                    next_wdata = {1'b0, r_n};
                end
                n_state = pdl_pkg::S_EMIT;
            end
            pdl_pkg::S_WALK: begin
                rd_addr = r_cur;
                if (r_cnt == '0) begin
                    n_state = pdl_pkg::S_FETCH;
                end else begin
                    n_cnt   = r_cnt - IW'(1);
                    n_state = pdl_pkg::S_STEP;
                end
            end
            pdl_pkg::S_STEP: begin
                n_cur   = next_rdata[IW-1:0];
                n_state = pdl_pkg::S_WALK;
            end
            pdl_pkg::S_FETCH: begin
                n_res.node_index = {1'b0, r_cur};
                n_res.data_out   = pay_rdata;
                n_state          = pdl_pkg::S_EMIT;
            end
            pdl_pkg::S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = pdl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pdl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= pdl_pkg::NIL;
            r_tail      <= pdl_pkg::NIL;
            r_count     <= '0;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_op   <= n_op;
        r_tgt  <= n_tgt;
        r_pos  <= n_pos;
        r_data <= n_data;
        r_t    <= n_t;
        r_n    <= n_n;
        r_link <= n_link;
        r_cur  <= n_cur;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // The node count always equals the number of live marks.
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_live) == 32'(r_count))
        else $error("node count disagrees with live marks");

    // An allocation never takes a node that is already in the list.
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdl_pkg::S_WR1 && r_op != pdl_pkg::OP_RELEASE) |-> !r_live[alloc_n])
        else $error("allocated node is live");

    // A released node is live when it is unlinked.
    a_release_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdl_pkg::S_WR1 && r_op == pdl_pkg::OP_RELEASE) |-> r_live[r_t])
        else $error("released node is not live");

endmodule

// File: tb/pdl_tb_if_note.sv
// Testbench support: scoreboard class for the pooled doubly linked list block.
// Depends on pdl_pkg; holds its own copy of the list state and predicts every response.
package pdl_tb_pkg;
    import pdl_pkg::*;

    class pdl_list_scoreboard;
        logic [NODE_W-1:0]  nxt [POOL_SIZE];
        logic [NODE_W-1:0]  prv [POOL_SIZE];
        logic [DATA_W-1:0]  pay [POOL_SIZE];
        logic [NODE_W-1:0]  fnext [POOL_SIZE];
        bit                 live [POOL_SIZE];
        logic [NODE_W-1:0]  free_top, head, tail, count;
        t_result            pending_rsp [$];
        int                 errors;

        function new();
            for (int i = 0; i < POOL_SIZE; i++) begin
                nxt[i] = NIL;
                prv[i] = NIL;
                pay[i] = '0;
                fnext[i] = NODE_W'(i + 1);
                live[i] = 0;
            end
            free_top = '0;
            head = NIL;
            tail = NIL;
            count = '0;
            errors = 0;
        endfunction

        function bit is_live(logic [NODE_W-1:0] n);
            return n < NIL && live[n[IDX_W-1:0]];
        endfunction

        function logic [NODE_W-1:0] take_node(logic [DATA_W-1:0] d);
            logic [NODE_W-1:0] n;
            n = free_top;
            if (count >= NODE_W'(POOL_SIZE) || n >= NIL) return NIL;
            free_top = fnext[n];
            live[n] = 1;
            pay[n] = d;
            prv[n] = NIL;
            nxt[n] = NIL;
            count++;
            return n;
        endfunction

        function void give_back(logic [NODE_W-1:0] n);
            logic [NODE_W-1:0] p, q;
            p = prv[n];
            q = nxt[n];
            if (p < NIL) nxt[p] = q; else head = q;
            if (q < NIL) prv[q] = p; else tail = p;
            live[n] = 0;
            fnext[n] = free_top;
            free_top = n;
            if (count > 0) count--;
        endfunction

        function void splice_before(logic [NODE_W-1:0] t, logic [NODE_W-1:0] n);
            logic [NODE_W-1:0] p;
            p = prv[t];
            prv[n] = p;
            nxt[n] = t;
            if (p < NIL) nxt[p] = n; else head = n;
            prv[t] = n;
        endfunction

        function void splice_after(logic [NODE_W-1:0] t, logic [NODE_W-1:0] n);
            logic [NODE_W-1:0] q;
            q = nxt[t];
            nxt[n] = q;
            prv[n] = t;
            if (q < NIL) prv[q] = n; else tail = n;
            nxt[t] = n;
        endfunction

        // Applies one accepted request to the shadow list and queues its response.
        function void note_request(t_mode md, logic [IDX_W-1:0] tgt_in,
                                   logic [IDX_W-1:0] pos, logic [DATA_W-1:0] d);
            t_result r;
            logic [NODE_W-1:0] n, tgt;
            tgt = {1'b0, tgt_in};
            r.status = ST_OK;
            r.node_index = NIL;
            r.data_out = '0;
            case (md)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    n = take_node(d);
                    if (n >= NIL) r.status = ST_FULL;
                    else begin
                        if (head >= NIL) begin
                            head = n;
                            tail = n;
                        end else if (md == MODE_PUSH_FRONT) splice_before(head, n);
                        else splice_after(tail, n);
                        r.node_index = n;
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK: begin
                    n = (md == MODE_POP_FRONT) ? head : tail;
                    if (count == 0 || !is_live(n)) r.status = ST_EMPTY;
                    else begin
                        r.data_out = pay[n];
                        give_back(n);
                        r.node_index = n;
                    end
                end
                MODE_INS_BEFORE, MODE_INS_AFTER: begin
                    if (!is_live(tgt)) r.status = ST_BAD;
                    else begin
                        n = take_node(d);
                        if (n >= NIL) r.status = ST_FULL;
                        else begin
                            if (md == MODE_INS_BEFORE) splice_before(tgt, n);
                            else splice_after(tgt, n);
                            r.node_index = n;
                        end
                    end
                end
                MODE_REMOVE: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (!is_live(tgt)) r.status = ST_BAD;
                    else begin
                        r.data_out = pay[tgt];
                        give_back(tgt);
                        r.node_index = tgt;
                    end
                end
                default: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if ({1'b0, pos} >= count) r.status = ST_BAD;
                    else begin
                        n = head;
                        for (int i = 0; i < pos && n < NIL; i++) n = nxt[n];
                        if (n >= NIL) r.status = ST_BAD;
                        else begin
                            r.node_index = n;
                            r.data_out = pay[n];
                        end
                    end
                end
            endcase
            r.list_length = count;
            pending_rsp.push_back(r);
        endfunction

        function void check_response(t_result got, realtime t);
            t_result want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with none expected: %p", t, got);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status != want.status) begin
                $display("%0t: status expected %0d actual %0d", t, want.status, got.status);
                errors++;
            end
            if (got.node_index != want.node_index) begin
                $display("%0t: node_index expected %0d actual %0d", t, want.node_index,
                         got.node_index);
                errors++;
            end
            if (got.data_out != want.data_out) begin
                $display("%0t: data_out expected %h actual %h", t, want.data_out, got.data_out);
                errors++;
            end
            if (got.list_length != want.list_length) begin
                $display("%0t: list_length expected %0d actual %0d", t, want.list_length,
                         got.list_length);
                errors++;
            end
        endfunction
    endclass
endpackage

// File: tb/tb_pooled_doubly_linked_list_top.sv
// Testbench top for pooled_doubly_linked_list_top: directed and random list operations,
// random idling on both channels, responses checked against the scoreboard's shadow list.
// Depends on pdl_pkg, pdl_if, pdl_tb_pkg and the RTL.
module tb_pooled_doubly_linked_list_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 2000000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    longint cycles = 0;
    int     rsp_seen = 0;
    bit     rx_fast = 0;

    pdl_req_if req ();
    pdl_rsp_if rsp ();

    pdl_tb_pkg::pdl_list_scoreboard board = new();

    pooled_doubly_linked_list_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        req.valid = 1'b0;
        req.mode = pdl_pkg::MODE_PUSH_FRONT;
        req.target_node = '0;
        req.position = '0;
        req.data_in = '0;
        rsp.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pooled_doubly_linked_list_top test failed");
            $finish;
        end
    end

    // Response side: after each item, ready drops for a random gap unless the phase runs fast.
    initial begin : rx_side
        int gap;
        pdl_pkg::t_result got;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = rx_fast ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            @(posedge i_clk iff rsp.valid === 1'b1);
            got.status = pdl_pkg::t_status'(rsp.status);
            got.node_index = rsp.node_index;
            got.data_out = rsp.data_out;
            got.list_length = rsp.list_length;
            board.check_response(got, $realtime);
            rsp_seen++;
        end
    end

    bit tx_fast = 0;

    task automatic send_op(pdl_pkg::t_mode md, int tgt, int pos,
                           logic [pdl_pkg::DATA_W-1:0] d);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.mode <= md;
        req.target_node <= pdl_pkg::IDX_W'(tgt);
        req.position <= pdl_pkg::IDX_W'(pos);
        req.data_in <= d;
        @(posedge i_clk iff req.ready === 1'b1);
        board.note_request(md, pdl_pkg::IDX_W'(tgt), pdl_pkg::IDX_W'(pos), d);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (board.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Picks a live node most of the time so inserts and removes reach the list.
    function automatic int pick_target();
        int k;
        logic [pdl_pkg::NODE_W-1:0] n;
        if (board.count != 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, board.count - 1);
            n = board.head;
            for (int j = 0; j < k; j++) n = board.nxt[n[pdl_pkg::IDX_W-1:0]];
            return int'(n);
        end
        return $urandom_range(0, 63);
    endfunction

    initial begin : tx_side
        int m, burst;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: empty-list cases, extremes, every operation.
        send_op(pdl_pkg::MODE_POP_FRONT, 0, 0, '0);
        send_op(pdl_pkg::MODE_POP_BACK, 0, 0, '0);
        send_op(pdl_pkg::MODE_REMOVE, 63, 0, '0);
        send_op(pdl_pkg::MODE_GET_NTH, 0, 0, '0);
        send_op(pdl_pkg::MODE_INS_BEFORE, 0, 0, '1);
        send_op(pdl_pkg::MODE_INS_AFTER, 63, 0, '1);
        send_op(pdl_pkg::MODE_PUSH_FRONT, 0, 0, 32'hFFFF_FFFF);
        send_op(pdl_pkg::MODE_POP_BACK, 0, 0, '0);
        send_op(pdl_pkg::MODE_PUSH_BACK, 63, 63, 32'h0000_0000);
        send_op(pdl_pkg::MODE_INS_BEFORE, 0, 0, 32'hA5A5_5A5A);
        send_op(pdl_pkg::MODE_INS_AFTER, 0, 0, 32'h5A5A_A5A5);
        send_op(pdl_pkg::MODE_INS_AFTER, 1, 0, 32'h1234_5678);
        send_op(pdl_pkg::MODE_GET_NTH, 0, 3, '0);
        send_op(pdl_pkg::MODE_GET_NTH, 0, 4, '0);
        send_op(pdl_pkg::MODE_GET_NTH, 0, 63, '0);
        send_op(pdl_pkg::MODE_REMOVE, 50, 0, '0);
        send_op(pdl_pkg::MODE_REMOVE, 0, 0, '0);
        send_op(pdl_pkg::MODE_POP_FRONT, 0, 0, '0);
        // Fill the pool to the brim, then push and insert onto a full pool.
        while (board.count < pdl_pkg::POOL_SIZE) begin
            send_op(pdl_pkg::MODE_PUSH_BACK, 0, 0, $urandom());
        end
        send_op(pdl_pkg::MODE_PUSH_FRONT, 0, 0, '1);
        send_op(pdl_pkg::MODE_INS_BEFORE, board.head, 0, '1);
        send_op(pdl_pkg::MODE_GET_NTH, 0, 63, '0);
        drain();
        // Random phase; bursts vary the bias toward growing or shrinking the list.
        for (int i = 0; i < 800; i++) begin
            if (i % 100 == 0) begin
                burst = $urandom_range(0, 2);
                tx_fast = (i % 200 == 100);
                rx_fast = (i % 300 == 0);
            end
            if (i == 400) drain();
            m = $urandom_range(0, 9);
            if (burst == 0 && m < 3) m = $urandom_range(0, 1);
            if (burst == 1 && m < 3) m = $urandom_range(2, 3);
            case (m)
                0: send_op(pdl_pkg::MODE_PUSH_FRONT, $urandom_range(0, 63),
                           $urandom_range(0, 63), $urandom());
                1: send_op(pdl_pkg::MODE_PUSH_BACK, $urandom_range(0, 63),
                           $urandom_range(0, 63), $urandom());
                2: send_op(pdl_pkg::MODE_POP_FRONT, $urandom_range(0, 63),
                           $urandom_range(0, 63), $urandom());
                3: send_op(pdl_pkg::MODE_POP_BACK, $urandom_range(0, 63),
                           $urandom_range(0, 63), $urandom());
                4: send_op(pdl_pkg::MODE_INS_BEFORE, pick_target(), $urandom_range(0, 63),
                           $urandom());
                5: send_op(pdl_pkg::MODE_INS_AFTER, pick_target(), $urandom_range(0, 63),
                           $urandom());
                6: send_op(pdl_pkg::MODE_REMOVE, pick_target(), $urandom_range(0, 63),
                           $urandom());
                default: send_op(pdl_pkg::MODE_GET_NTH, $urandom_range(0, 63),
                                 (board.count != 0 && $urandom_range(0, 3) != 0) ?
                                 $urandom_range(0, board.count - 1) : $urandom_range(0, 63),
                                 $urandom());
            endcase
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending_rsp.size() == 0) begin
            $display("pooled_doubly_linked_list_top test passed");
        end else begin
            $display("pooled_doubly_linked_list_top test failed");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/pdl_pkg.sv
hdl/pdl_if.sv
hdl/pdl_ram.sv
hdl/pooled_doubly_linked_list_top.sv
tb/pdl_tb_if_note.sv
tb/tb_pooled_doubly_linked_list_top.sv
